// ===== rtl/djts_pkg.sv =====
// Shared constants for the deadline job table scheduler.
`default_nettype none
package djts_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int TAG_WIDTH   = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic REQ_QUEUE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [1:0] ST_QUEUED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_FIRED  = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/deadline_job_table_scheduler_top.sv =====
// Top level of the deadline job table scheduler: job table, scan and close-up sequencer.
//
//   Input channel (i_in_valid / o_in_stall) carries one request word: a queue
//   request (i_req_type = 0) with i_job_tag and i_due_time, or a tick
//   (i_req_type = 1) with i_current_time. Every request word produces exactly
//   one result word on the output channel (o_out_valid / i_out_stall):
//   o_status, o_fired_tag and o_pending_count.
//   A queue request or a tick on an empty table goes straight to the done
//   state. A tick scans from the cursor toward the tail through the
//   registered read port and one due-time comparator, one entry per cycle;
//   a fired job is closed up by copying each later entry down one slot, one
//   per cycle, and the done state then hands over the result. Scan and
//   close-up cover the table once. A new queue request is not taken until
//   the done state has handed the previous result to the output register.
//   One request is in work at a time: o_in_stall is high while the sequencer
//   is busy. The result sits in an output register, so a new request is taken
//   while an earlier result still waits; the sequencer holds its next result
//   until the output register is free.
//   Reset (i_rst_n low, synchronous) empties the table, parks the cursor at
//   end and drops any pending result. Table contents are not cleared.
`default_nettype none
module deadline_job_table_scheduler_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_req_type,
    input  wire logic [djts_pkg::TAG_WIDTH-1:0]  i_job_tag,
    input  wire logic [djts_pkg::TIME_WIDTH-1:0] i_due_time,
    input  wire logic [djts_pkg::TIME_WIDTH-1:0] i_current_time,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic [djts_pkg::TAG_WIDTH-1:0]     o_fired_tag,
    output logic [djts_pkg::CNT_W-1:0]         o_pending_count
);
    localparam int IW = djts_pkg::IDX_W;
    localparam int CW = djts_pkg::CNT_W;
    localparam int TW = djts_pkg::TIME_WIDTH;
    localparam int GW = djts_pkg::TAG_WIDTH;
    localparam logic [CW-1:0] DEPTH = CW'(djts_pkg::TABLE_DEPTH);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // job table, one write and one registered read port
    logic [GW-1:0] mem_tag [djts_pkg::TABLE_DEPTH];
    logic [TW-1:0] mem_due [djts_pkg::TABLE_DEPTH];

    logic [1:0]    r_state,   n_state;
    logic [CW-1:0] r_count,   n_count;
    logic [CW-1:0] r_cursor,  n_cursor;
    logic [CW-1:0] r_idx,     n_idx;     // next entry to read
    logic [IW-1:0] r_pos,     n_pos;     // entry held in read data / copy target
    logic          r_chk,     n_chk;     // read data is live
    logic [TW-1:0] r_now,     n_now;
    logic [1:0]    r_res_st,  n_res_st;
    logic [GW-1:0] r_res_tag, n_res_tag;
    logic          r_out_valid;
    logic [1:0]    r_out_st;
    logic [GW-1:0] r_out_tag;
    logic [CW-1:0] r_out_cnt;

    logic [GW-1:0] r_rd_tag;
    logic [TW-1:0] r_rd_due;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [GW-1:0] mem_wtag;
    logic [TW-1:0] mem_wdue;
    logic          in_take;
    logic          out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_chk     = r_chk;
        n_now     = r_now;
        n_res_st  = r_res_st;
        n_res_tag = r_res_tag;
        mem_we    = 1'b0;
        mem_wa    = r_pos;
        mem_wtag  = r_rd_tag;
        mem_wdue  = r_rd_due;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_res_tag = '0;
                    n_now     = i_current_time;
                    if (i_req_type == djts_pkg::REQ_QUEUE) begin
                        n_state = S_DONE;
                        if (r_count >= DEPTH) begin
                            n_res_st = djts_pkg::ST_FULL;
                        end else begin
                            // append at tail; a cursor at end follows the tail
                            mem_we   = 1'b1;
                            mem_wa   = r_count[IW-1:0];
                            mem_wtag = i_job_tag;
                            mem_wdue = i_due_time;
                            n_count  = r_count + 1'b1;
                            if (r_cursor >= r_count) begin
                                n_cursor = r_count + 1'b1;
                            end
                            n_res_st = djts_pkg::ST_QUEUED;
                        end
                    end else if (r_count == '0) begin
                        n_state  = S_DONE;
                        n_res_st = djts_pkg::ST_IDLE;
                    end else begin
                        // wrap a cursor at end to the first entry
                        n_idx   = (r_cursor >= r_count) ? '0 : r_cursor;
                        n_chk   = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk && (r_rd_due <= r_now)) begin
                    // fire: start closing up from the successor
                    n_res_st  = djts_pkg::ST_FIRED;
                    n_res_tag = r_rd_tag;
                    n_cursor  = CW'(r_pos);
                    n_idx     = CW'(r_pos) + 1'b1;
                    n_chk     = 1'b0;
                    n_state   = S_SHIFT;
                end else if (r_idx < r_count) begin
                    n_pos = r_idx[IW-1:0];
                    n_chk = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_res_st = djts_pkg::ST_IDLE;
                    n_cursor = r_count;
                    n_chk    = 1'b0;
                    n_state  = S_DONE;
                end
            end
            S_SHIFT: begin
                // drop the entry read last cycle one slot lower
                mem_we = r_chk;
                if (r_idx < r_count) begin
                    n_pos = IW'(r_idx - 1'b1);
                    n_chk = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_chk   = 1'b0;
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_tag[mem_wa] <= mem_wtag;
            mem_due[mem_wa] <= mem_wdue;
        end
        r_rd_tag <= mem_tag[r_idx[IW-1:0]];
        r_rd_due <= mem_due[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_idx       <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_idx    <= n_idx;
            r_chk    <= n_chk;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_now     <= n_now;
        r_res_st  <= n_res_st;
        r_res_tag <= n_res_tag;
        if (r_state == S_DONE && out_free) begin
            r_out_st  <= r_res_st;
            r_out_tag <= r_res_tag;
            r_out_cnt <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_st;
    assign o_fired_tag     = r_out_tag;
    assign o_pending_count = r_out_cnt;
endmodule
`default_nettype wire
